/* src/tlbpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes, codes and types for the TLB / page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int OFFSET_BITS = 8;

  localparam int ADDR_W     = 16;
  localparam int PAGE_BITS  = $clog2(PAGE_COUNT);
  localparam int FRAME_BITS = PAGE_BITS;
  localparam int MAP_W      = FRAME_BITS + 1;
  localparam int TLB_IDX_W  = $clog2(TLB_ENTRIES);
  localparam int TLB_CNT_W  = $clog2(TLB_ENTRIES + 1);
  localparam int CNT_W      = 32;
  localparam int OUTCOME_W  = 2;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_TLB_HIT = 2'd0,
    OUT_MAP_HIT = 2'd1,
    OUT_FAULT   = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

endpackage

/* src/tlb_page_table_translator_top.sv */
// The input word and its page map RAM read are registered on accept; the
//   TLB update, map write-back and result word follow in the lookup state,
//   which waits while the previous result is not taken. No new word is taken until it ends.
// Reset: synchronous, active low. Afterwards the page map RAM is swept clear,
//   one entry per cycle, with in_ready low until it is done.
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top
// Logical to physical address translation: LRU TLB in front of a page map
// RAM, with in-order frame allocation on page faults.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_top
  import tlbpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ADDR_W-1:0]      in_logical_address,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ADDR_W-1:0]      out_physical_address,
  output logic [OUTCOME_W-1:0]   out_outcome,
  output logic [CNT_W-1:0]       out_hit_count,
  output logic [CNT_W-1:0]       out_fault_count
);

  state_t state_r, state_nxt;

  logic [PAGE_BITS-1:0]   clr_idx_r;
  logic [PAGE_BITS-1:0]   page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [MAP_W-1:0]       map_rdata_r;
  logic [MAP_W-1:0]       pmap_mem [PAGE_COUNT];

  logic [PAGE_BITS-1:0]   tlb_tag_r   [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]  tlb_frame_r [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   tlb_tag_nxt   [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]  tlb_frame_nxt [TLB_ENTRIES];
  logic [TLB_CNT_W-1:0]   fill_r, fill_nxt;

  logic [FRAME_BITS-1:0]  next_free_r;
  logic [CNT_W-1:0]       hits_r, hits_nxt;
  logic [CNT_W-1:0]       faults_r, faults_nxt;

  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_pa_r;
  outcome_t               out_outcome_r;
  logic [CNT_W-1:0]       out_hits_r;
  logic [CNT_W-1:0]       out_faults_r;

  logic                   in_acc;
  logic                   lk_go;
  logic [ADDR_W+PAGE_BITS-1:0] in_page_wide;
  logic [PAGE_BITS-1:0]   in_page;

  logic                   tlb_hit;
  logic [TLB_IDX_W-1:0]   hit_idx;
  logic                   tlb_full;
  logic                   shift_en;
  logic [TLB_IDX_W-1:0]   rm_idx;
  logic [TLB_CNT_W-1:0]   dest_cnt;
  logic [TLB_IDX_W-1:0]   dest_idx;
  logic                   map_valid;
  logic                   fault;
  logic [FRAME_BITS-1:0]  frame_sel;
  outcome_t               outcome;
  logic [ADDR_W+FRAME_BITS-1:0] pa_wide;

  logic                   mem_we;
  logic [PAGE_BITS-1:0]   mem_waddr;
  logic [MAP_W-1:0]       mem_wdata;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign lk_go    = (state_r == ST_LOOK) && (!out_valid_r || out_ready);

  // page number taken modulo the page map size
  assign in_page_wide = (ADDR_W+PAGE_BITS)'(in_logical_address >> OFFSET_BITS);
  assign in_page      = in_page_wide[PAGE_BITS-1:0];

  // ---- FSM ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_idx_r == {PAGE_BITS{1'b1}}) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_LOOK;
      ST_LOOK:  if (lk_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // ---- TLB search: lowest matching slot below the fill level ----
  always_comb begin
    tlb_hit = 1'b0;
    hit_idx = '0;
    for (int j = TLB_ENTRIES - 1; j >= 0; j--) begin
      if ((TLB_CNT_W'(j) < fill_r) && (tlb_tag_r[j] == page_r)) begin
        tlb_hit = 1'b1;
        hit_idx = TLB_IDX_W'(j);
      end
    end
  end

  assign map_valid = map_rdata_r[FRAME_BITS];
  assign fault     = !tlb_hit && !map_valid;
  assign tlb_full  = (fill_r == TLB_CNT_W'(TLB_ENTRIES));

  always_comb begin
    if (tlb_hit) begin
      frame_sel = tlb_frame_r[hit_idx];
      outcome   = OUT_TLB_HIT;
    end else if (map_valid) begin
      frame_sel = map_rdata_r[FRAME_BITS-1:0];
      outcome   = OUT_MAP_HIT;
    end else begin
      frame_sel = next_free_r;
      outcome   = OUT_FAULT;
    end
  end

  // LRU update: drop the hit slot (or slot 0 when full), close the gap,
  // append the page as most recent
  assign shift_en = tlb_hit || tlb_full;
  assign rm_idx   = tlb_hit ? hit_idx : '0;
  assign dest_cnt = shift_en ? (fill_r - 1'b1) : fill_r;
  assign dest_idx = dest_cnt[TLB_IDX_W-1:0];
  assign fill_nxt = shift_en ? fill_r : (fill_r + 1'b1);

  always_comb begin
    for (int j = 0; j < TLB_ENTRIES; j++) begin
      tlb_tag_nxt[j]   = tlb_tag_r[j];
      tlb_frame_nxt[j] = tlb_frame_r[j];
      if (shift_en && (TLB_IDX_W'(j) >= rm_idx) && (TLB_CNT_W'(j + 1) < fill_r)) begin
        tlb_tag_nxt[j]   = tlb_tag_r[(j + 1) % TLB_ENTRIES];
        tlb_frame_nxt[j] = tlb_frame_r[(j + 1) % TLB_ENTRIES];
      end
      if (TLB_IDX_W'(j) == dest_idx) begin
        tlb_tag_nxt[j]   = page_r;
        tlb_frame_nxt[j] = frame_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lk_go) begin
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        tlb_tag_r[j]   <= tlb_tag_nxt[j];
        tlb_frame_r[j] <= tlb_frame_nxt[j];
      end
    end
  end

  // ---- saturating counters ----
  assign hits_nxt   = (tlb_hit && hits_r != {CNT_W{1'b1}}) ? hits_r + 1'b1 : hits_r;
  assign faults_nxt = (fault && faults_r != {CNT_W{1'b1}}) ? faults_r + 1'b1 : faults_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      next_free_r <= '0;
      hits_r      <= '0;
      faults_r    <= '0;
    end else if (lk_go) begin
      fill_r   <= fill_nxt;
      hits_r   <= hits_nxt;
      faults_r <= faults_nxt;
      if (fault) next_free_r <= next_free_r + 1'b1;
    end
  end

  // ---- page map RAM: clear sweep or fault write-back, read on accept ----
  assign mem_we    = (state_r == ST_CLEAR) || (lk_go && fault);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_idx_r : page_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : {1'b1, next_free_r};

  always_ff @(posedge clk) begin
    if (mem_we) pmap_mem[mem_waddr] <= mem_wdata;
    if (in_acc) map_rdata_r <= pmap_mem[in_page];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r   <= in_page;
      offset_r <= in_logical_address[OFFSET_BITS-1:0];
    end
  end

  // ---- result word register ----
  assign pa_wide = ((ADDR_W+FRAME_BITS)'(frame_sel) << OFFSET_BITS)
                 | (ADDR_W+FRAME_BITS)'(offset_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lk_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_go) begin
      out_pa_r      <= pa_wide[ADDR_W-1:0];
      out_outcome_r <= outcome;
      out_hits_r    <= hits_nxt;
      out_faults_r  <= faults_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_outcome          = out_outcome_r;
  assign out_hit_count        = out_hits_r;
  assign out_fault_count      = out_faults_r;

endmodule

/* tb/tb_tlb_page_table_translator_top.sv */
// ----------------------------------------------------------------------------
// tb_tlb_page_table_translator_top
// Checks TLB and page map address translation against an LRU TLB and page map
// model kept here. Directed corners first, then random accesses drawn mostly
// from a drifting working set, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translator_top;
  import tlbpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 400;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [ADDR_W-1:0] phys;
    outcome_t          outcome;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  faults;
  } xlate_t;

  typedef struct {
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } tlb_entry_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADDR_W-1:0]    in_logical_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    out_physical_address;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [CNT_W-1:0]     out_hit_count;
  logic [CNT_W-1:0]     out_fault_count;

  logic [ADDR_W-1:0] pending_addrs[$];
  xlate_t            expected_xlates[$];
  int                total_words = 0;
  int                accepted_words = 0;
  int                error_count = 0;

  // model state: lru_q front is least recently used
  tlb_entry_t            lru_q[$];
  bit                    map_valid[PAGE_COUNT];
  logic [FRAME_BITS-1:0] map_frame[PAGE_COUNT];
  int                    next_frame = 0;
  logic [CNT_W-1:0]      tlb_hits = '0;
  logic [CNT_W-1:0]      page_faults = '0;

  int send_gap = 0;
  int recv_stall = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  tlb_page_table_translator_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_logical_address   (in_logical_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_physical_address (out_physical_address),
    .out_outcome          (out_outcome),
    .out_hit_count        (out_hit_count),
    .out_fault_count      (out_fault_count)
  );

  always #5 clk = ~clk;

  function automatic xlate_t translate_address(logic [ADDR_W-1:0] addr);
    logic [PAGE_BITS-1:0]   page;
    logic [OFFSET_BITS-1:0] offs;
    logic [FRAME_BITS-1:0]  frame;
    tlb_entry_t             ent;
    xlate_t                 r;
    int                     slot;
    page = PAGE_BITS'((addr >> OFFSET_BITS) % PAGE_COUNT);
    offs = addr[OFFSET_BITS-1:0];
    slot = -1;
    foreach (lru_q[i])
      if (slot < 0 && lru_q[i].page == page) slot = i;
    if (slot >= 0) begin
      frame = lru_q[slot].frame;
      lru_q.delete(slot);
      tlb_hits = (tlb_hits == '1) ? tlb_hits : tlb_hits + 1;
      r.outcome = OUT_TLB_HIT;
    end else if (map_valid[page]) begin
      frame = map_frame[page];
      r.outcome = OUT_MAP_HIT;
    end else begin
      frame = FRAME_BITS'(next_frame % PAGE_COUNT);
      map_valid[page] = 1'b1;
      map_frame[page] = frame;
      next_frame = (next_frame + 1) % PAGE_COUNT;
      page_faults = (page_faults == '1) ? page_faults : page_faults + 1;
      r.outcome = OUT_FAULT;
    end
    if (lru_q.size() >= TLB_ENTRIES) lru_q.delete(0);
    ent.page = page;
    ent.frame = frame;
    lru_q.insert(lru_q.size(), ent);
    r.phys = ADDR_W'((int'(frame) << OFFSET_BITS) | int'(offs));
    r.hits = tlb_hits;
    r.faults = page_faults;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long; calm runs have none
  function automatic int pick_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic check_field(string fname, logic [CNT_W-1:0] exp_v,
                             logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_xlates.insert(expected_xlates.size(),
                               translate_address(in_logical_address));
        accepted_words++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_addrs.size() != 0) begin
          in_valid <= 1'b1;
          in_logical_address <= pending_addrs[0];
          pending_addrs.delete(0);
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    xlate_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_xlates.size() == 0) begin
          $display("%0t: result word with none expected, physical_address %0h",
                   $time, out_physical_address);
          error_count++;
        end else begin
          want = expected_xlates[0];
          expected_xlates.delete(0);
          check_field("physical_address", CNT_W'(want.phys), CNT_W'(out_physical_address));
          check_field("outcome", CNT_W'(want.outcome), CNT_W'(out_outcome));
          check_field("hit_count", want.hits, out_hit_count);
          check_field("fault_count", want.faults, out_fault_count);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_stall = pick_gap(recv_calm);
      end
    end
  end

  initial begin
    int                     hot_base;
    int                     r;
    logic [PAGE_BITS-1:0]   page;
    logic [OFFSET_BITS-1:0] offs;

    // page 0 fault then TLB hit, same for page 255, offsets at both ends
    pending_addrs.insert(pending_addrs.size(), 16'h0000);
    pending_addrs.insert(pending_addrs.size(), 16'h00FF);
    pending_addrs.insert(pending_addrs.size(), 16'hFFFF);
    pending_addrs.insert(pending_addrs.size(), 16'hFF00);
    // fill the TLB past capacity: page 0 is evicted as LRU
    for (int p = 1; p <= 15; p++)
      pending_addrs.insert(pending_addrs.size(),
                           {PAGE_BITS'(p), (p % 2) ? 8'hA5 : 8'h5A});
    // evicted pages 0 and 255 come back through the page map, then two new pages fault
    pending_addrs.insert(pending_addrs.size(), 16'h0012);
    pending_addrs.insert(pending_addrs.size(), 16'hFF34);
    pending_addrs.insert(pending_addrs.size(), 16'hAAAA);
    pending_addrs.insert(pending_addrs.size(), 16'h5555);

    hot_base = $urandom_range(0, PAGE_COUNT - 1);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 49) == 0) hot_base = $urandom_range(0, PAGE_COUNT - 1);
      r = $urandom_range(0, 9);
      if (r < 5)
        page = PAGE_BITS'(hot_base + $urandom_range(0, TLB_ENTRIES - 4));
      else if (r < 8)
        page = PAGE_BITS'(hot_base + $urandom_range(0, 3 * TLB_ENTRIES));
      else
        page = PAGE_BITS'($urandom_range(0, PAGE_COUNT - 1));
      offs = OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1));
      pending_addrs.insert(pending_addrs.size(), {page, offs});
    end
    total_words = pending_addrs.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_words < total_words) @(posedge clk);
    while (expected_xlates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
